// ----- sv/ccm_pkg.sv -----
// ============================================================================
// CCM* frame engine package
// Shared types, register indexes, the AES S-box and small helper functions.
// ============================================================================
package ccm_pkg;

    localparam int NONCE_BYTES     = 13;
    localparam int MAX_FRAME_BYTES = 128;
    localparam int AES_ROUNDS      = 10;

    typedef enum logic [2:0] {
        REG_KEY_HIGH       = 3'd0,
        REG_KEY_LOW        = 3'd1,
        REG_NONCE_HIGH     = 3'd2,
        REG_NONCE_LOW      = 3'd3,
        REG_SEC_LEVEL      = 3'd4,
        REG_DECRYPT_MODE   = 3'd5,
        REG_HEADER_LENGTH  = 3'd6,
        REG_BODY_LENGTH    = 3'd7
    } t_reg_index;

    typedef enum logic [1:0] {
        SRC_B0     = 2'd0,
        SRC_A0     = 2'd1,
        SRC_ACTR   = 2'd2,
        SRC_ABSORB = 2'd3
    } t_src;

    typedef enum logic [1:0] {
        DST_MAC  = 2'd0,
        DST_TAG  = 2'd1,
        DST_KS   = 2'd2,
        DST_NONE = 2'd3
    } t_dst;

    typedef enum logic [1:0] {
        RGN_HEADER  = 2'd0,
        RGN_PAYLOAD = 2'd1,
        RGN_TAG     = 2'd2,
        RGN_NONE    = 2'd3
    } t_region;

    typedef struct packed {
        logic [127:0]             key;
        logic [NONCE_BYTES*8-1:0] nonce;
        logic [2:0]               sec_level;
        logic                     decrypt_mode;
        logic [6:0]               header_length;
        logic [6:0]               body_length;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic aes_start;
        t_src aes_src;
        t_dst aes_dst;
        logic fill_clr;
        logic la_push;
        logic frame_clr;
        logic ctr_inc;
        logic push;
        logic cmp;
        logic adv;
        logic tag_emit;
        logic verd_emit;
    } t_cmd;

    typedef struct packed {
        logic    pos_zero;
        t_region region;
        logic    enc;
        logic    dec;
        logic    off_zero;
        logic    off_blk;
        logic    fill_nz;
        logic    fill_last;
        logic    end_now;
        logic    la_nz;
        logic    mlen_zero;
        logic    tag_last;
        logic    out_free;
        logic    aes_done;
    } t_status;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [4:0] mic_len(input logic [1:0] code);
        logic [4:0] m;
        case (code)
            2'd0:    m = 5'd0;
            2'd1:    m = 5'd4;
            2'd2:    m = 5'd8;
            default: m = 5'd16;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] mic_flag(input logic [1:0] code);
        logic [2:0] f;
        case (code)
            2'd0:    f = 3'd0;
            2'd1:    f = 3'd1;
            2'd2:    f = 3'd3;
            default: f = 3'd7;
        endcase
        return f;
    endfunction

endpackage

// ----- sv/ccm_aes_core.sv -----
// ============================================================================
// CCM* AES-128 core
// Iterative AES-128 encryption, one round per cycle with on-the-fly key
// expansion.
// ============================================================================
module ccm_aes_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_src,
    input  logic [127:0] i_key,
    output logic         o_done,
    output logic [127:0] o_block
);

    logic [127:0] r_st, n_st;
    logic [127:0] r_rk, n_rk;
    logic [7:0]   r_rcon;
    logic [3:0]   r_rnd;
    logic         r_busy;
    logic         r_done;

    always_comb begin
        logic [7:0]  sb  [16];
        logic [7:0]  sr  [16];
        logic [7:0]  mx  [16];
        logic [7:0]  a0, a1, a2, a3, all;
        logic [31:0] w0, w1, w2, w3, t;
        for (int j = 0; j < 16; j++) begin
            sb[j] = ccm_pkg::SBOX[r_st[127-8*j -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sr[i+4*c] = sb[i + 4*((c+i) & 3)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = sr[4*c];
            a1  = sr[4*c+1];
            a2  = sr[4*c+2];
            a3  = sr[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            mx[4*c]   = a0 ^ all ^ ccm_pkg::xt(a0 ^ a1);
            mx[4*c+1] = a1 ^ all ^ ccm_pkg::xt(a1 ^ a2);
            mx[4*c+2] = a2 ^ all ^ ccm_pkg::xt(a2 ^ a3);
            mx[4*c+3] = a3 ^ all ^ ccm_pkg::xt(a3 ^ a0);
        end
        t = {ccm_pkg::SBOX[r_rk[23:16]] ^ r_rcon, ccm_pkg::SBOX[r_rk[15:8]],
             ccm_pkg::SBOX[r_rk[7:0]], ccm_pkg::SBOX[r_rk[31:24]]};
        w0 = r_rk[127:96] ^ t;
        w1 = r_rk[95:64] ^ w0;
        w2 = r_rk[63:32] ^ w1;
        w3 = r_rk[31:0] ^ w2;
        n_rk = {w0, w1, w2, w3};
        for (int j = 0; j < 16; j++) begin
            n_st[127-8*j -: 8] = ((r_rnd == 4'(ccm_pkg::AES_ROUNDS)) ? sr[j] : mx[j])
                                 ^ n_rk[127-8*j -: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= 4'd1;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 4'd1;
                if (r_rnd == 4'(ccm_pkg::AES_ROUNDS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_st   <= i_src ^ i_key;
            r_rk   <= i_key;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_st   <= n_st;
            r_rk   <= n_rk;
            r_rcon <= ccm_pkg::xt(r_rcon);
        end
    end

    assign o_done  = r_done;
    assign o_block = r_st;

endmodule

// ----- sv/ccm_datapath.sv -----
// ============================================================================
// CCM* datapath
// Holds the CBC-MAC chain, block buffer, counter, tag mask, keystream,
// frame position and the result register, and drives the AES core.
// ============================================================================
module ccm_datapath #(
    parameter int MAX_FRAME_BYTES = ccm_pkg::MAX_FRAME_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ccm_pkg::t_cfg    i_cfg,
    input  ccm_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_data,
    input  logic             i_last,
    output ccm_pkg::t_status o_status,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [15:0]      o_m_tdata,
    output logic [1:0]       o_m_tuser,
    output logic             o_m_tlast
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 17);
    localparam logic [PW-1:0] MAXV = PW'(MAX_FRAME_BYTES);

    logic [127:0] r_mac, r_tmask, r_ks;
    logic [7:0]   r_buf [16];
    logic [4:0]   r_fill;
    logic [15:0]  r_ctr;
    logic [PW-1:0] r_pos;
    logic [7:0]   r_byte;
    logic         r_last;
    logic         r_mism;
    logic         r_complete;
    logic [3:0]   r_tidx;
    ccm_pkg::t_dst r_dst;

    logic         r_ovalid, r_otag, r_overd, r_ook, r_olast;
    logic [7:0]   r_obyte;

    logic [PW-1:0] hl_c, pl_c, hp, total, pos_n, off, tpos;
    logic [4:0]    mlen;
    logic          enc, dec;
    logic [15:0]   la, lm;
    ccm_pkg::t_region region;
    logic [127:0]  aes_src, aes_out, buf_vec;
    logic          aes_done;
    logic [7:0]    ks_b, o_pay, push_v, mac_b, tm_b;
    logic [3:0]    sel;

    assign mlen  = ccm_pkg::mic_len(i_cfg.sec_level[1:0]);
    assign enc   = i_cfg.sec_level[2];
    assign dec   = i_cfg.decrypt_mode;
    assign hl_c  = (PW'(i_cfg.header_length) > MAXV) ? MAXV : PW'(i_cfg.header_length);
    assign pl_c  = (PW'(i_cfg.body_length) > (MAXV - hl_c)) ? (MAXV - hl_c)
                                                            : PW'(i_cfg.body_length);
    assign hp    = hl_c + pl_c;
    assign total = hp + (dec ? PW'(mlen) : {PW{1'b0}});
    assign la    = enc ? 16'(hl_c) : 16'(hp);
    assign lm    = enc ? 16'(pl_c) : 16'd0;
    assign pos_n = r_pos + PW'(1);
    assign off   = r_pos - hl_c;
    assign tpos  = r_pos - hp;

    always_comb begin
        if (r_pos < hl_c) begin
            region = ccm_pkg::RGN_HEADER;
        end else if (r_pos < hp) begin
            region = ccm_pkg::RGN_PAYLOAD;
        end else if (r_pos < total) begin
            region = ccm_pkg::RGN_TAG;
        end else begin
            region = ccm_pkg::RGN_NONE;
        end
    end

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            buf_vec[127-8*j -: 8] = (5'(j) < r_fill) ? r_buf[j] : 8'h00;
        end
    end

    always_comb begin
        case (i_cmd.aes_src)
            ccm_pkg::SRC_B0: begin
                aes_src = {1'b0, (la != 16'd0), ccm_pkg::mic_flag(i_cfg.sec_level[1:0]),
                           3'b001, i_cfg.nonce, lm};
            end
            ccm_pkg::SRC_A0:   aes_src = {8'h01, i_cfg.nonce, 16'd0};
            ccm_pkg::SRC_ACTR: aes_src = {8'h01, i_cfg.nonce, r_ctr + 16'd1};
            default:           aes_src = r_mac ^ buf_vec;
        endcase
    end

    ccm_aes_core u_aes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.aes_start),
        .i_src   (aes_src),
        .i_key   (i_cfg.key),
        .o_done  (aes_done),
        .o_block (aes_out)
    );

    assign sel    = i_cmd.tag_emit ? r_tidx : tpos[3:0];
    assign ks_b   = r_ks[127-8*off[3:0] -: 8];
    assign mac_b  = r_mac[127-8*sel -: 8];
    assign tm_b   = r_tmask[127-8*sel -: 8];
    assign o_pay  = enc ? (r_byte ^ ks_b) : r_byte;
    assign push_v = (region == ccm_pkg::RGN_PAYLOAD && enc && !dec) ? r_byte
                  : ((region == ccm_pkg::RGN_PAYLOAD) ? o_pay : r_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac      <= '0;
            r_tmask    <= '0;
            r_ks       <= '0;
            r_fill     <= 5'd0;
            r_ctr      <= 16'd0;
            r_pos      <= '0;
            r_mism     <= 1'b0;
            r_complete <= 1'b0;
            r_tidx     <= 4'd0;
            r_dst      <= ccm_pkg::DST_NONE;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.aes_start) begin
                r_dst <= i_cmd.aes_dst;
            end
            if (aes_done) begin
                case (r_dst)
                    ccm_pkg::DST_MAC: r_mac   <= aes_out;
                    ccm_pkg::DST_TAG: r_tmask <= aes_out;
                    ccm_pkg::DST_KS:  r_ks    <= aes_out;
                    default: ;
                endcase
            end
            if (i_cmd.fill_clr) begin
                r_fill <= 5'd0;
            end else if (i_cmd.la_push) begin
                r_fill <= 5'd2;
            end else if (i_cmd.push) begin
                r_fill <= r_fill + 5'd1;
            end
            if (i_cmd.frame_clr) begin
                r_ctr  <= 16'd0;
                r_mism <= 1'b0;
            end
            if (i_cmd.ctr_inc) begin
                r_ctr <= r_ctr + 16'd1;
            end
            if (i_cmd.cmp && (r_byte != (mac_b ^ tm_b))) begin
                r_mism <= 1'b1;
            end
            if (i_cmd.adv) begin
                if (r_last || (pos_n >= total)) begin
                    r_pos      <= '0;
                    r_complete <= (pos_n >= total);
                    r_tidx     <= 4'd0;
                end else begin
                    r_pos <= pos_n;
                end
            end
            if (i_cmd.tag_emit) begin
                r_tidx <= r_tidx + 4'd1;
            end
            if ((i_cmd.push && region == ccm_pkg::RGN_PAYLOAD) || i_cmd.tag_emit
                    || i_cmd.verd_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_data;
            r_last <= i_last;
        end
        if (i_cmd.la_push) begin
            r_buf[0] <= la[15:8];
            r_buf[1] <= la[7:0];
        end
        if (i_cmd.push) begin
            r_buf[r_fill[3:0]] <= push_v;
        end
        if (i_cmd.push && region == ccm_pkg::RGN_PAYLOAD) begin
            r_obyte <= o_pay;
            r_otag  <= 1'b0;
            r_overd <= 1'b0;
            r_ook   <= 1'b0;
            r_olast <= (r_last || (pos_n >= total)) && !dec && (mlen == 5'd0);
        end else if (i_cmd.tag_emit) begin
            r_obyte <= mac_b ^ tm_b;
            r_otag  <= 1'b1;
            r_overd <= 1'b0;
            r_ook   <= 1'b0;
            r_olast <= (5'(r_tidx) == mlen - 5'd1);
        end else if (i_cmd.verd_emit) begin
            r_obyte <= 8'h00;
            r_otag  <= 1'b0;
            r_overd <= 1'b1;
            r_ook   <= r_complete && !r_mism;
            r_olast <= 1'b1;
        end
    end

    assign o_status.pos_zero  = (r_pos == '0);
    assign o_status.region    = region;
    assign o_status.enc       = enc;
    assign o_status.dec       = dec;
    assign o_status.off_zero  = (off == '0);
    assign o_status.off_blk   = (off[3:0] == 4'd0);
    assign o_status.fill_nz   = (r_fill != 5'd0);
    assign o_status.fill_last = (r_fill == 5'd15);
    assign o_status.end_now   = r_last || (pos_n >= total);
    assign o_status.la_nz     = (la != 16'd0);
    assign o_status.mlen_zero = (mlen == 5'd0);
    assign o_status.tag_last  = (5'(r_tidx) == mlen - 5'd1);
    assign o_status.out_free  = !r_ovalid;
    assign o_status.aes_done  = aes_done;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_ook, r_obyte};
    assign o_m_tuser  = {r_overd, r_otag};
    assign o_m_tlast  = r_olast;

endmodule

// ----- sv/ccm_ctrl.sv -----
// ============================================================================
// CCM* controller
// Sequences the per-byte work: frame start, MAC absorption, keystream
// generation, tag comparison and result emission.
// ============================================================================
module ccm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ccm_pkg::t_status i_status,
    output ccm_pkg::t_cmd    o_cmd
);

    typedef enum logic [16:0] {
        ST_IDLE  = 17'b00000000000000001,
        ST_B0    = 17'b00000000000000010,
        ST_B0W   = 17'b00000000000000100,
        ST_LA    = 17'b00000000000001000,
        ST_A0    = 17'b00000000000010000,
        ST_A0W   = 17'b00000000000100000,
        ST_CLASS = 17'b00000000001000000,
        ST_ABS   = 17'b00000000010000000,
        ST_ABSW  = 17'b00000000100000000,
        ST_KS    = 17'b00000001000000000,
        ST_KSW   = 17'b00000010000000000,
        ST_PUSH  = 17'b00000100000000000,
        ST_CMP   = 17'b00001000000000000,
        ST_ADV   = 17'b00010000000000000,
        ST_FIN   = 17'b00100000000000000,
        ST_TAG   = 17'b01000000000000000,
        ST_VERD  = 17'b10000000000000000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        o_cmd.aes_src = ccm_pkg::SRC_ABSORB;
        o_cmd.aes_dst = ccm_pkg::DST_MAC;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_status.pos_zero ? ST_B0 : ST_CLASS;
                end
            end
            ST_B0: begin
                o_cmd.aes_start = 1'b1;
                o_cmd.aes_src   = ccm_pkg::SRC_B0;
                o_cmd.fill_clr  = 1'b1;
                n_state = ST_B0W;
            end
            ST_B0W: begin
                if (i_status.aes_done) begin
                    n_state = i_status.la_nz ? ST_LA : ST_A0;
                end
            end
            ST_LA: begin
                o_cmd.la_push = 1'b1;
                n_state = ST_A0;
            end
            ST_A0: begin
                o_cmd.aes_start = 1'b1;
                o_cmd.aes_src   = ccm_pkg::SRC_A0;
                o_cmd.aes_dst   = ccm_pkg::DST_TAG;
                o_cmd.frame_clr = 1'b1;
                n_state = ST_A0W;
            end
            ST_A0W: begin
                if (i_status.aes_done) begin
                    n_state = ST_CLASS;
                end
            end
            ST_CLASS: begin
                case (i_status.region)
                    ccm_pkg::RGN_HEADER: n_state = ST_PUSH;
                    ccm_pkg::RGN_PAYLOAD: begin
                        if (!i_status.enc) begin
                            n_state = ST_PUSH;
                        end else if (i_status.off_zero && i_status.fill_nz) begin
                            n_state = ST_ABS;
                            n_ret   = ST_CLASS;
                        end else if (i_status.off_blk) begin
                            n_state = ST_KS;
                        end else begin
                            n_state = ST_PUSH;
                        end
                    end
                    ccm_pkg::RGN_TAG: begin
                        if (i_status.fill_nz) begin
                            n_state = ST_ABS;
                            n_ret   = ST_CLASS;
                        end else begin
                            n_state = ST_CMP;
                        end
                    end
                    default: n_state = ST_ADV;
                endcase
            end
            ST_ABS: begin
                o_cmd.aes_start = 1'b1;
                o_cmd.fill_clr  = 1'b1;
                n_state = ST_ABSW;
            end
            ST_ABSW: begin
                if (i_status.aes_done) begin
                    n_state = r_ret;
                end
            end
            ST_KS: begin
                o_cmd.aes_start = 1'b1;
                o_cmd.aes_src   = ccm_pkg::SRC_ACTR;
                o_cmd.aes_dst   = ccm_pkg::DST_KS;
                o_cmd.ctr_inc   = 1'b1;
                n_state = ST_KSW;
            end
            ST_KSW: begin
                if (i_status.aes_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_status.fill_last) begin
                        n_state = ST_ABS;
                        n_ret   = ST_ADV;
                    end else begin
                        n_state = ST_ADV;
                    end
                end
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = ST_ADV;
            end
            ST_ADV: begin
                o_cmd.adv = 1'b1;
                n_state = i_status.end_now ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (i_status.fill_nz) begin
                    n_state = ST_ABS;
                    n_ret   = ST_FIN;
                end else if (i_status.dec) begin
                    n_state = ST_VERD;
                end else if (i_status.mlen_zero) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_TAG;
                end
            end
            ST_TAG: begin
                if (i_status.out_free) begin
                    o_cmd.tag_emit = 1'b1;
                    if (i_status.tag_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_VERD: begin
                if (i_status.out_free) begin
                    o_cmd.verd_emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ----- sv/ccm_star_frame_crypto_unit.sv -----
// ============================================================================
// CCM* frame crypto unit
// AES-128 CCM* engine with a 13-byte nonce and a 2-byte length field.
// ============================================================================
// Bytes are taken one at a time and processed one at a time. Each AES pass
// runs on the single iterative AES core, one round per cycle. The
// first byte of a frame runs two passes (B0 and the tag mask block), an
// encrypted payload byte that opens a 16-byte block runs a keystream pass,
// and each completed MAC block runs one more. Results wait in one output
// register.
module ccm_star_frame_crypto_unit #(
    parameter int MAX_FRAME_BYTES = ccm_pkg::MAX_FRAME_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tlast,   // last_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // out_byte, auth_ok, zero fill
    output logic [1:0]  o_m_tuser,   // is_tag, is_verdict
    output logic        o_m_tlast,   // last_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    ccm_pkg::t_cfg    r_cfg;
    ccm_pkg::t_cmd    cmd;
    ccm_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (ccm_pkg::t_reg_index'(i_cfg_index))
                ccm_pkg::REG_KEY_HIGH:       r_cfg.key[127:64]      <= i_cfg_data;
                ccm_pkg::REG_KEY_LOW:        r_cfg.key[63:0]        <= i_cfg_data;
                ccm_pkg::REG_NONCE_HIGH:     r_cfg.nonce[103:64]    <= i_cfg_data[39:0];
                ccm_pkg::REG_NONCE_LOW:      r_cfg.nonce[63:0]      <= i_cfg_data;
                ccm_pkg::REG_SEC_LEVEL:      r_cfg.sec_level        <= i_cfg_data[2:0];
                ccm_pkg::REG_DECRYPT_MODE:   r_cfg.decrypt_mode     <= i_cfg_data[0];
                ccm_pkg::REG_HEADER_LENGTH:  r_cfg.header_length    <= i_cfg_data[6:0];
                ccm_pkg::REG_BODY_LENGTH:    r_cfg.body_length      <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    ccm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ccm_datapath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .i_data     (i_s_tdata),
        .i_last     (i_s_tlast),
        .o_status   (status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> o_m_tlast)
        else $error("verdict request without last flag");

    a_kind_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("request marked both tag and verdict");

    a_ok_only_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[8]) |-> o_m_tuser[1])
        else $error("auth_ok set outside a verdict");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a byte is in progress");

endmodule

// ----- dv/tb_ccm_star_frame_crypto_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// CCM* frame crypto unit testbench
// Drives whole frames through the byte stream under directed and random
// security levels in both directions, with clean, truncated and corrupted
// frames. It encrypts its own decrypt frames to build valid tags. An in-bench
// CCM* model predicts each output request; the checker compares them in order.
// ============================================================================
module tb_ccm_star_frame_crypto_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    ccm_star_frame_crypto_unit dut (.*);

    typedef struct packed {
        logic [7:0] ob;
        logic       tg;
        logic       vd;
        logic       ok;
        logic       lst;
    } t_res;

    typedef struct {
        bit [127:0] mac;
        bit [127:0] bbuf;
        bit [127:0] mask;
        bit [127:0] ks;
        int         fill;
        int         ctr;
        int         pos;
        bit         mism;
    } t_ccm_state;

    typedef enum {FR_GOOD, FR_EARLY, FR_BADTAG} t_kind;

    typedef struct {
        int    sec;
        int    dec;
        int    hl;
        int    pl;
        t_kind kind;
        int    keysel;
        int    ok;
    } t_row;

    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int MIC_TAB [4]  = '{0, 4, 8, 16};

    bit [63:0] key_hi_q, key_lo_q, nonce_lo_q;
    bit [39:0] nonce_hi_q;
    bit [2:0]  sec_q;
    bit        dec_q;
    bit [6:0]  hl_q, pl_q;

    t_ccm_state st;
    t_res       step_out[$];
    t_res       exp_q[$];
    t_res       got, want;

    int  n_items, n_frames, n_results, n_errors, n_ok_verdicts;
    bit  calm, rx_hold;

    t_row rows [9] = '{
        '{7, 0, 1, 1, FR_GOOD,   0, -1},
        '{7, 1, 1, 1, FR_GOOD,   1,  1},
        '{7, 1, 1, 1, FR_BADTAG, 1,  0},
        '{5, 1, 0, 2, FR_EARLY,  2,  0},
        '{4, 0, 0, 1, FR_GOOD,   1, -1},
        '{3, 0, 2, 0, FR_GOOD,   2, -1},
        '{1, 1, 0, 0, FR_GOOD,   0,  1},
        '{6, 1, 1, 1, FR_GOOD,   2,  1},
        '{0, 0, 0, 0, FR_GOOD,   2, -1}
    };

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- model
    function automatic bit [7:0] dbl(bit [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic bit [127:0] aes_enc(bit [127:0] src);
        bit [7:0]   rk [16];
        bit [7:0]   s [16];
        bit [7:0]   t [16];
        bit [7:0]   rc, a0, a1, a2, a3, al;
        bit [127:0] k, res;
        k  = {key_hi_q, key_lo_q};
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = k[127-8*i -: 8];
            s[i]  = src[127-8*i -: 8] ^ rk[i];
        end
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) s[i] = ccm_pkg::SBOX[s[i]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i) % 4)];
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    s[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                    s[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                    s[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                    s[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            end else begin
                s = t;
            end
            rk[0] ^= ccm_pkg::SBOX[rk[13]] ^ rc;
            rk[1] ^= ccm_pkg::SBOX[rk[14]];
            rk[2] ^= ccm_pkg::SBOX[rk[15]];
            rk[3] ^= ccm_pkg::SBOX[rk[12]];
            for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
            rc = dbl(rc);
            for (int i = 0; i < 16; i++) s[i] ^= rk[i];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    function automatic bit [127:0] ctr_block(bit [7:0] flags, bit [15:0] tail);
        return {flags, nonce_hi_q, nonce_lo_q, tail};
    endfunction

    function automatic void mac_absorb();
        st.mac  = aes_enc(st.mac ^ st.bbuf);
        st.fill = 0;
    endfunction

    function automatic void mac_push(bit [7:0] v);
        st.bbuf[127-8*st.fill -: 8] = v;
        st.fill++;
        if (st.fill >= 16) mac_absorb();
    endfunction

    function automatic void mac_flush();
        if (st.fill == 0) return;
        while (st.fill < 16) begin
            st.bbuf[127-8*st.fill -: 8] = 8'h00;
            st.fill++;
        end
        mac_absorb();
    endfunction

    function automatic bit [7:0] tag_byte(int i);
        return st.mac[127-8*i -: 8] ^ st.mask[127-8*i -: 8];
    endfunction

    function automatic void ccm_step(bit [7:0] b, bit lst);
        int       mlen, hl, pl, tot, la, lm, pos, off;
        bit       enc, dec;
        bit [7:0] flags, o;
        step_out.delete();
        mlen = MIC_TAB[sec_q[1:0]];
        enc  = sec_q[2];
        dec  = dec_q;
        hl   = hl_q;
        pl   = pl_q;
        if (pl > ccm_pkg::MAX_FRAME_BYTES - hl) pl = ccm_pkg::MAX_FRAME_BYTES - hl;
        tot = hl + pl + (dec ? mlen : 0);
        la  = enc ? hl : hl + pl;
        lm  = enc ? pl : 0;
        pos = st.pos;
        if (pos == 0) begin
            flags = 8'h01;
            if (la > 0) flags |= 8'h40;
            if (mlen > 0) flags |= 8'(((mlen - 2) / 2) << 3);
            st.mac  = aes_enc(ctr_block(flags, 16'(lm)));
            st.fill = 0;
            if (la > 0) begin
                mac_push(8'(la >> 8));
                mac_push(8'(la));
            end
            st.mask = aes_enc(ctr_block(8'h01, 16'h0000));
            st.ctr  = 0;
            st.mism = 0;
        end
        if (pos < hl) begin
            mac_push(b);
        end else if (pos < hl + pl) begin
            off = pos - hl;
            o   = b;
            if (enc) begin
                if (off == 0) mac_flush();
                if (off % 16 == 0) begin
                    st.ctr++;
                    st.ks = aes_enc(ctr_block(8'h01, 16'(st.ctr)));
                end
                o = b ^ st.ks[127-8*(off % 16) -: 8];
                mac_push(dec ? o : b);
            end else begin
                mac_push(b);
            end
            step_out.push_back('{o, 1'b0, 1'b0, 1'b0, 1'b0});
        end else if (pos < tot) begin
            mac_flush();
            if (b != tag_byte((pos - hl - pl) % 16)) st.mism = 1;
        end
        pos++;
        if (lst || pos >= tot) begin
            mac_flush();
            if (!dec) begin
                if (mlen == 0) begin
                    if (step_out.size() > 0) step_out[step_out.size()-1].lst = 1'b1;
                end else begin
                    for (int i = 0; i < mlen; i++)
                        step_out.push_back('{tag_byte(i), 1'b1, 1'b0, 1'b0, i == mlen - 1});
                end
            end else begin
                step_out.push_back('{8'h00, 1'b0, 1'b1, (pos >= tot) && !st.mism, 1'b1});
            end
            st.pos = 0;
        end else begin
            st.pos = pos;
        end
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic reg_write(ccm_pkg::t_reg_index idx, bit [63:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ccm_pkg::REG_KEY_HIGH:      key_hi_q   = v;
            ccm_pkg::REG_KEY_LOW:       key_lo_q   = v;
            ccm_pkg::REG_NONCE_HIGH:    nonce_hi_q = v[39:0];
            ccm_pkg::REG_NONCE_LOW:     nonce_lo_q = v;
            ccm_pkg::REG_SEC_LEVEL:     sec_q      = v[2:0];
            ccm_pkg::REG_DECRYPT_MODE:  dec_q      = v[0];
            ccm_pkg::REG_HEADER_LENGTH: hl_q       = v[6:0];
            ccm_pkg::REG_BODY_LENGTH:   pl_q       = v[6:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(int keysel, int sec, int dec, int hl, int pl);
        bit [63:0] k0, k1, n0, n1;
        k0 = {$urandom, $urandom}; k1 = {$urandom, $urandom};
        n0 = {$urandom, $urandom}; n1 = {$urandom, $urandom};
        if (keysel == 0) begin
            k0 = '0; k1 = '0; n0 = '0; n1 = '0;
        end else if (keysel == 1) begin
            k0 = '1; k1 = '1; n0 = '1; n1 = '1;
        end
        reg_write(ccm_pkg::REG_KEY_HIGH, k0);
        reg_write(ccm_pkg::REG_KEY_LOW, k1);
        reg_write(ccm_pkg::REG_NONCE_HIGH, n0);
        reg_write(ccm_pkg::REG_NONCE_LOW, n1);
        reg_write(ccm_pkg::REG_SEC_LEVEL, 64'(sec));
        reg_write(ccm_pkg::REG_DECRYPT_MODE, 64'(dec));
        reg_write(ccm_pkg::REG_HEADER_LENGTH, 64'(hl));
        reg_write(ccm_pkg::REG_BODY_LENGTH, 64'(pl));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put_byte(bit [7:0] b, bit lst, int typed_ok);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        n_items++;
        ccm_step(b, lst);
        foreach (step_out[i]) begin
            if (step_out[i].vd && typed_ok >= 0) step_out[i].ok = typed_ok[0];
            exp_q.push_back(step_out[i]);
        end
    endtask

    task automatic send_frame(t_kind kind, int typed_ok);
        bit [7:0]   fb[$];
        bit [7:0]   tagb[$];
        t_ccm_state saved;
        int         hl, pl, n, cut, j;
        bit         lst;
        hl = hl_q;
        pl = pl_q;
        if (pl > ccm_pkg::MAX_FRAME_BYTES - hl) pl = ccm_pkg::MAX_FRAME_BYTES - hl;
        for (int i = 0; i < hl + pl; i++) fb.push_back(8'($urandom));
        if (dec_q) begin
            // Encrypt the chosen plaintext first so the frame carries a valid tag.
            saved = st;
            dec_q = 1'b0;
            n = (hl + pl == 0) ? 1 : hl + pl;
            for (int i = 0; i < n; i++) begin
                ccm_step(i < fb.size() ? fb[i] : 8'h00, i == n - 1);
                foreach (step_out[r]) begin
                    if (step_out[r].tg) tagb.push_back(step_out[r].ob);
                    else fb[i] = step_out[r].ob;
                end
            end
            st    = saved;
            dec_q = 1'b1;
            if (kind == FR_BADTAG && tagb.size() > 0) begin
                j = $urandom_range(0, tagb.size() - 1);
                tagb[j] ^= 8'(1 << $urandom_range(0, 7));
            end
            foreach (tagb[i]) fb.push_back(tagb[i]);
        end
        if (fb.size() == 0) fb.push_back(8'($urandom));
        cut = fb.size();
        if (kind == FR_EARLY && cut > 1) cut = $urandom_range(1, cut - 1);
        for (int i = 0; i < cut; i++) begin
            lst = (i == cut - 1) ? ((kind == FR_EARLY) ? 1'b1 : 1'($urandom_range(0, 1)))
                                 : 1'b0;
            put_byte(fb[i], lst, typed_ok);
        end
        n_frames++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        wait (exp_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- receiver
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                rx_hold = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (!calm && i_rst_n && $urandom_range(0, 9) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[7:0], o_m_tuser[0], o_m_tuser[1], o_m_tdata[8], o_m_tlast};
            n_results++;
            if (exp_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: unexpected output request byte=%h tag=%b verdict=%b ok=%b last=%b",
                             $realtime, got.ob, got.tg, got.vd, got.ok, got.lst);
            end else begin
                want = exp_q.pop_front();
                if (got.vd && got.ok) n_ok_verdicts++;
                if (got != want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: mismatch exp byte=%h tag=%b verdict=%b ok=%b last=%b, got byte=%h tag=%b verdict=%b ok=%b last=%b",
                                 $realtime, want.ob, want.tg, want.vd, want.ok, want.lst,
                                 got.ob, got.tg, got.vd, got.ok, got.lst);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        int phase, hl, pl;
        i_clk = 1'b0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        st = '{default: 0};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With reset registers the frame is empty: its one byte is dropped.
        put_byte(8'hff, 1'b1, -1);
        drain();
        foreach (rows[i]) begin
            program_regs(rows[i].keysel, rows[i].sec, rows[i].dec, rows[i].hl, rows[i].pl);
            send_frame(rows[i].kind, rows[i].ok);
            drain();
        end

        phase = 0;
        while (n_items < 460) begin
            calm = (n_items > 400);
            hl = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 20);
            pl = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 24);
            if (phase == 3) begin
                hl = 127;
                pl = 127;
            end
            program_regs($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2,
                         $urandom_range(0, 7), $urandom_range(0, 1), hl, pl);
            if (phase == 2) rx_hold = 1'b1;
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0:       send_frame(FR_EARLY, -1);
                    1, 2:    send_frame(FR_BADTAG, -1);
                    default: send_frame(FR_GOOD, -1);
                endcase
            end
            drain();
            phase++;
        end

        $display("Covered %0d bytes in %0d frames over %0d register settings.",
                 n_items, n_frames, phase + 10);
        $display("Checked %0d output requests, %0d passing verdicts, %0d mismatches.",
                 n_results, n_ok_verdicts, n_errors);
        if (n_errors == 0 && exp_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
